/* rtl/lls_pkg.sv */
package lls_pkg;

  // Default geometry: Q3.20 samples, Q.16 coefficients
  localparam int unsigned LLS_SAMPLE_WIDTH   = 24;
  localparam int unsigned LLS_COEF_FRAC_BITS = 16;

  // Configuration register map
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POLE     = 2'd2;

  localparam int unsigned CUTOFF_RESET   = 6554;
  localparam int unsigned FEEDBACK_RESET = 0;
  localparam logic [1:0]  POLE_RESET     = 2'd3;

  // Operations of the shared multiplier, in issue order for one channel
  typedef enum logic [2:0] {
    OP_FEEDBACK = 3'd0,  // r * (s4 + previous s4)
    OP_POLE1    = 3'd1,  // g * (x - fb - s1)
    OP_SQUARE   = 3'd2,  // |v| * |v|
    OP_RECIP    = 3'd3,  // (a^2 / 16) * reciprocal of 27
    OP_CUBE     = 3'd4,  // q * |v|
    OP_POLE2    = 3'd5,
    OP_POLE3    = 3'd6,
    OP_POLE4    = 3'd7
  } lls_op_e;

  typedef struct packed {
    logic    vld;
    logic    ch;
    lls_op_e op;
  } lls_tag_t;

endpackage

/* rtl/lls_if.sv */
interface lls_in_if import lls_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = LLS_SAMPLE_WIDTH
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_left;
  logic signed [SAMPLE_WIDTH-1:0] sample_right;

  modport source (output valid, output sample_left, output sample_right, input ready);
  modport sink   (input valid, input sample_left, input sample_right, output ready);
endinterface

interface lls_out_if import lls_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = LLS_SAMPLE_WIDTH
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] out_left;
  logic signed [SAMPLE_WIDTH-1:0] out_right;

  modport source (output valid, output out_left, output out_right, input ready);
  modport sink   (input valid, input out_left, input out_right, output ready);
endinterface

/* rtl/ladder_lowpass_stereo_unit.sv */
// Channel   Direction  Handshake            Payload
// in_i      sink       valid / ready        sample_left, sample_right (signed Q3.20)
// out_o     source     valid / ready        out_left, out_right (signed Q3.20)
// cfg       write      cfg_we_i             cfg_idx_i, cfg_data_i
//
// Per stereo pair, 16 multiplies share one pipelined signed multiplier, left and right
// interleaved in groups of a left slot, a right slot and a gap slot, then drain and
// result load; a new pair is taken only once the previous result is in the output register.
// Reset clears the filter state and sequencer and restores the default configuration.
// A new pair is taken while a finished result still waits in the output register;
// if that result is still waiting at the end of the next pair, the sequencer holds.
module ladder_lowpass_stereo_unit import lls_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH   = LLS_SAMPLE_WIDTH,
  parameter int unsigned COEF_FRAC_BITS = LLS_COEF_FRAC_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  lls_in_if.sink                      in_i,
  lls_out_if.source                   out_o,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [COEF_FRAC_BITS+1:0]   cfg_data_i
);

  localparam int unsigned W  = SAMPLE_WIDTH;
  localparam int unsigned F  = COEF_FRAC_BITS;
  localparam int unsigned SF = W - 4;           // sample fraction bits
  localparam int unsigned TW = W + 6;           // scratch width (feedback, pre-clip value)
  localparam int unsigned AW = W + 5;           // multiplier operand A
  localparam int unsigned BW = (F + 3 > W + 3) ? F + 3 : W + 3;  // operand B
  localparam int unsigned PW = AW + BW;         // product
  // floor(n / 432) = floor((n >> 4) / 27); (n >> 4) < 2^(SF+4), so a reciprocal
  // with K = SF + 4 + 5 fraction bits is exact for every operand
  localparam int unsigned K  = SF + 9;
  localparam logic [63:0] RECIP27_WIDE = ((64'd1 << K) + 64'd26) / 64'd27;
  localparam logic [BW-1:0] RECIP27    = BW'(RECIP27_WIDE);
  localparam int unsigned DIV_ROUND    = 216;   // half of 432
  localparam int unsigned DIV_PRESHIFT = 4;

  localparam logic signed [W-1:0]  SMAX     = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  SMIN     = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [TW-1:0] SMAX_X   = TW'(SMAX);
  localparam logic signed [TW-1:0] SMIN_X   = TW'(SMIN);
  localparam logic signed [TW-1:0] CLIP_BIG = TW'(12) <<< SF;
  localparam logic signed [PW-1:0] HALF_F   = PW'(1) <<< (F - 1);
  localparam logic signed [PW-1:0] HALF_S   = PW'(1) <<< (SF - 1);

  // Sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  // Issue slots within one operation: left, right, gap
  localparam logic [1:0] PH_LEFT  = 2'd0;
  localparam logic [1:0] PH_RIGHT = 2'd1;
  localparam logic [1:0] PH_GAP   = 2'd2;
  localparam logic [2:0] OP_LAST  = 3'(OP_POLE4);

  function automatic logic signed [W-1:0] sat_w(input logic signed [TW-1:0] x);
    if (x > SMAX_X) begin
      return SMAX;
    end else if (x < SMIN_X) begin
      return SMIN;
    end
    return W'(x);
  endfunction

  // Configuration
  logic [F-1:0]   cutoff_q;
  logic [F+1:0]   feedback_q;
  logic [1:0]     pole_sel_q;

  // Filter state, per channel (0 left, 1 right)
  logic signed [W-1:0] st_q [2][4];
  logic signed [W-1:0] prior_q [2];

  // Per-channel working registers
  logic signed [W-1:0]  in_q   [2];
  logic signed [TW-1:0] tmp_q  [2];
  logic        [W-1:0]  a_q    [2];
  logic                 neg_q  [2];
  logic                 big_q  [2];

  // Sequencer and pipeline
  logic [1:0]  state_q, state_d;
  logic [1:0]  ph_q;
  logic [2:0]  op_q;
  lls_tag_t    pre_tag, mul_tag_q, post_tag_q;

  logic signed [AW-1:0] opa_d, opa_q;
  logic signed [BW-1:0] opb_d, opb_q;
  logic signed [PW-1:0] prod_q;

  logic signed [W-1:0]  out_left_q, out_right_q;
  logic                 out_valid_q;

  logic in_xfer, out_load;

  assign in_i.ready    = (state_q == ST_IDLE);
  assign in_xfer       = in_i.valid && in_i.ready;
  assign out_load      = (state_q == ST_FIN) && (!out_valid_q || out_o.ready);
  assign out_o.valid   = out_valid_q;
  assign out_o.out_left  = out_left_q;
  assign out_o.out_right = out_right_q;

  // ---------------------------------------------------------------------------
  // Operand stage: pick the channel of this slot and form both multiplier inputs
  // ---------------------------------------------------------------------------
  logic                 pre_ch;
  logic signed [W-1:0]  ps0, ps1, ps2, ps3, ppr, pin;
  logic signed [TW-1:0] pt, pabs, pdiv;

  always_comb begin
    pre_ch  = ph_q[0];
    pre_tag = '{vld: (state_q == ST_RUN) && (ph_q != PH_GAP), ch: pre_ch,
                op: lls_op_e'(op_q)};
    ps0  = st_q[pre_ch][0];
    ps1  = st_q[pre_ch][1];
    ps2  = st_q[pre_ch][2];
    ps3  = st_q[pre_ch][3];
    ppr  = prior_q[pre_ch];
    pin  = in_q[pre_ch];
    pt   = tmp_q[pre_ch];
    pabs = pt[TW-1] ? -pt : pt;
    pdiv = pt + TW'(DIV_ROUND);
    opa_d = '0;
    opb_d = '0;
    case (pre_tag.op)
      OP_FEEDBACK: begin
        opa_d = AW'(ps3) + AW'(ppr);
        opb_d = BW'({1'b0, feedback_q});
      end
      OP_POLE1: begin
        // first stage input is the sample minus the feedback term
        opa_d = AW'(pin) - AW'(pt) - AW'(ps0);
        opb_d = BW'({1'b0, cutoff_q});
      end
      OP_SQUARE: begin
        opa_d = AW'({1'b0, pabs[W-1:0]});
        opb_d = BW'({1'b0, pabs[W-1:0]});
      end
      OP_RECIP: begin
        opa_d = AW'({1'b0, pdiv[W+DIV_PRESHIFT-1:DIV_PRESHIFT]});
        opb_d = RECIP27;
      end
      OP_CUBE: begin
        opa_d = AW'({1'b0, pt[W-1:0]});
        opb_d = BW'({1'b0, a_q[pre_ch]});
      end
      OP_POLE2: begin
        opa_d = AW'(ps0) - AW'(ps1);
        opb_d = BW'({1'b0, cutoff_q});
      end
      OP_POLE3: begin
        opa_d = AW'(ps1) - AW'(ps2);
        opb_d = BW'({1'b0, cutoff_q});
      end
      OP_POLE4: begin
        opa_d = AW'(ps2) - AW'(ps3);
        opb_d = BW'({1'b0, cutoff_q});
      end
      default: begin
        opa_d = '0;
        opb_d = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Writeback stage: round (or, for the reciprocal, truncate) the product and update the channel it belongs to
  // ---------------------------------------------------------------------------
  logic                 post_ch;
  logic signed [PW-1:0] rnd_f, rnd_s, rnd_k;
  logic signed [W-1:0]  qs0, qs1, qs2, qs3;
  logic signed [TW-1:0] a_ext, clip_diff, pole1_v;
  logic signed [W-1:0]  clip_st, pole2_st, pole3_st, pole4_st;

  always_comb begin
    post_ch = post_tag_q.ch;
    rnd_f   = (prod_q + HALF_F) >>> F;
    rnd_s   = (prod_q + HALF_S) >>> SF;
    rnd_k   = prod_q >>> K;
    qs0     = st_q[post_ch][0];
    qs1     = st_q[post_ch][1];
    qs2     = st_q[post_ch][2];
    qs3     = st_q[post_ch][3];
    a_ext   = TW'({1'b0, a_q[post_ch]});
    pole1_v = TW'(qs0) + TW'(rnd_f);
    // magnitude a - c, with the sign of the pre-clip value restored
    clip_diff = neg_q[post_ch] ? (TW'(rnd_s) - a_ext) : (a_ext - TW'(rnd_s));
    if (big_q[post_ch]) begin
      clip_st = neg_q[post_ch] ? SMIN : SMAX;
    end else begin
      clip_st = sat_w(clip_diff);
    end
    pole2_st = sat_w(TW'(qs1) + TW'(rnd_f));
    pole3_st = sat_w(TW'(qs2) + TW'(rnd_f));
    pole4_st = sat_w(TW'(qs3) + TW'(rnd_f));
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (ph_q == PH_GAP && op_q == OP_LAST) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last right-channel writeback happens in this cycle
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ph_q        <= PH_LEFT;
      op_q        <= '0;
      mul_tag_q   <= '0;
      post_tag_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      mul_tag_q  <= pre_tag;
      post_tag_q <= mul_tag_q;
      if (in_xfer) begin
        ph_q <= PH_LEFT;
        op_q <= '0;
      end else if (state_q == ST_RUN) begin
        // advance slot; the gap slot moves to the next operation
        if (ph_q == PH_GAP) begin
          ph_q <= PH_LEFT;
          op_q <= op_q + 3'd1;
        end else begin
          ph_q <= ph_q + 2'd1;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Configuration registers; writes to an unused index are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q   <= F'(CUTOFF_RESET);
      feedback_q <= (F+2)'(FEEDBACK_RESET);
      pole_sel_q <= POLE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CUTOFF:   cutoff_q   <= cfg_data_i[F-1:0];
        REG_FEEDBACK: feedback_q <= cfg_data_i;
        REG_POLE:     pole_sel_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Filter state: stage values and the previous fourth-stage value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 2; c++) begin
        for (int s = 0; s < 4; s++) begin
          st_q[c][s] <= '0;
        end
        prior_q[c] <= '0;
      end
    end else if (post_tag_q.vld) begin
      case (post_tag_q.op)
        OP_CUBE:  st_q[post_ch][0] <= clip_st;
        OP_POLE2: st_q[post_ch][1] <= pole2_st;
        OP_POLE3: st_q[post_ch][2] <= pole3_st;
        OP_POLE4: begin
          st_q[post_ch][3] <= pole4_st;
          prior_q[post_ch] <= qs3;
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q[0] <= in_i.sample_left;
      in_q[1] <= in_i.sample_right;
    end
    opa_q  <= opa_d;
    opb_q  <= opb_d;
    prod_q <= PW'(opa_q) * PW'(opb_q);
    if (pre_tag.vld && pre_tag.op == OP_SQUARE) begin
      a_q[pre_ch]   <= pabs[W-1:0];
      neg_q[pre_ch] <= pt[TW-1];
      big_q[pre_ch] <= (pabs >= CLIP_BIG);
    end
    if (post_tag_q.vld) begin
      case (post_tag_q.op)
        OP_FEEDBACK: tmp_q[post_ch] <= TW'(rnd_f);
        OP_POLE1:    tmp_q[post_ch] <= pole1_v;
        OP_SQUARE:   tmp_q[post_ch] <= TW'(rnd_s);
        OP_RECIP:    tmp_q[post_ch] <= TW'(rnd_k);
        default: ;
      endcase
    end
    if (out_load) begin
      out_left_q  <= st_q[0][pole_sel_q];
      out_right_q <= st_q[1][pole_sel_q];
    end
  end

endmodule

/* rtl/lls_checker.sv */
module lls_checker import lls_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = LLS_SAMPLE_WIDTH
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic signed [SAMPLE_WIDTH-1:0] out_left_i,
  input logic signed [SAMPLE_WIDTH-1:0] out_right_i
);

  logic       in_xfer, out_xfer;
  logic [1:0] pending_q;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  // pairs taken in whose result has not yet left
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 2'(in_xfer) - 2'(out_xfer);
    end
  end

  busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_i)
    else $error("input taken again right after a transfer");

  no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q != 2'd3)
    else $error("more than two pairs outstanding");

  no_invented_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pending_q != 2'd0)
    else $error("result shown with no pair outstanding");

  out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_left_i) && $stable(out_right_i))
    else $error("stalled result changed");

endmodule

bind ladder_lowpass_stereo_unit lls_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_lls_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_left_i  (out_o.out_left),
  .out_right_i (out_o.out_right)
);
